[rtl/mask_candidate_generator_defines.svh]
// assertion macros used by mcg_seq
`ifndef MASK_CANDIDATE_GENERATOR_DEFINES_SVH
`define MASK_CANDIDATE_GENERATOR_DEFINES_SVH

// same-cycle implication, disabled in reset
`define MCG_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, disabled in reset
`define MCG_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

[rtl/mcg_pkg.sv]
package mcg_pkg;

   // default sizes
   localparam int MAX_SLOTS_DEF     = 8;
   localparam int CHARSET_DEPTH_DEF = 256;
   localparam int MAX_BATCH_DEF     = 64;

   // field widths
   localparam int CMD_W    = 3;
   localparam int SLOT_W   = 3;
   localparam int POSF_W   = 8;
   localparam int CHAR_W   = 8;
   localparam int SIZEF_W  = 9;
   localparam int BATCHF_W = 7;
   localparam int COUNT_W  = 64;
   localparam int CAND_W   = 64;
   localparam int CSR_W    = 4;

   localparam logic [CSR_W-1:0] SLOT_COUNT_RST = 4'd6;

   // command codes
   typedef enum logic [CMD_W-1:0] {
      CMD_LOAD    = 3'd0,
      CMD_SIZE    = 3'd1,
      CMD_GEN     = 3'd2,
      CMD_POS     = 3'd3,
      CMD_COUNT   = 3'd4,
      CMD_RESTART = 3'd5
   } cmd_type;

   typedef enum logic {
      ST_IDLE,
      ST_RUN
   } st_type;

   typedef struct packed {
      cmd_type               command;
      logic [SLOT_W-1:0]     slot;
      logic [POSF_W-1:0]     position;
      logic [CHAR_W-1:0]     char_code;
      logic [SIZEF_W-1:0]    charset_size;
      logic [BATCHF_W-1:0]   batch_size;
      logic [COUNT_W-1:0]    count_value;
   } req_type;

   typedef struct packed {
      logic [CAND_W-1:0]     candidate;
      logic                  last_of_batch;
      logic                  exhausted;
      logic [COUNT_W-1:0]    generated_total;
   } rsp_type;

   // per-candidate flags and count from the sequencer
   typedef struct packed {
      logic                  last_of_batch;
      logic                  exhausted;
      logic [COUNT_W-1:0]    generated_total;
   } rsp_meta_type;

   // odometer controls
   typedef struct packed {
      logic clear;
      logic step;
      logic set_size;
      logic set_pos;
   } odo_ctl_type;

   // sequencer commands, already qualified by accept
   typedef struct packed {
      logic gen;
      logic set_count;
      logic restart;
      logic clr_done;
   } seq_cmd_type;

endpackage

[rtl/mcg_charset_mem.sv]
module mcg_charset_mem #(
   parameter int  MAX_SLOTS     = mcg_pkg::MAX_SLOTS_DEF,
   parameter int  CHARSET_DEPTH = mcg_pkg::CHARSET_DEPTH_DEF,
   localparam int POS_W         = $clog2(CHARSET_DEPTH)
) (
   input  logic                                clock,
   input  logic                                wr_en,
   input  logic [mcg_pkg::SLOT_W-1:0]          wr_slot,
   input  logic [POS_W-1:0]                    wr_addr,
   input  logic [mcg_pkg::CHAR_W-1:0]          wr_data,
   input  logic                                rd_en,
   input  logic [MAX_SLOTS*POS_W-1:0]          rd_addr_flat,
   output logic [MAX_SLOTS*mcg_pkg::CHAR_W-1:0] rd_data_flat
);
   import mcg_pkg::*;

   // one bank per slot so every slot is read in the same cycle
   for (genvar b = 0; b < MAX_SLOTS; b++) begin : g_bank
      logic [CHAR_W-1:0] mem_array [CHARSET_DEPTH];
      logic [CHAR_W-1:0] rd_data_ff;

      always_ff @(posedge clock) begin
         if (wr_en && (wr_slot == SLOT_W'(b))) begin
            mem_array[wr_addr] <= wr_data;
         end
         if (rd_en) begin
            rd_data_ff <= mem_array[rd_addr_flat[b*POS_W +: POS_W]];
         end
      end

      assign rd_data_flat[b*CHAR_W +: CHAR_W] = rd_data_ff;
   end

endmodule

[rtl/mcg_odometer.sv]
module mcg_odometer #(
   parameter int  MAX_SLOTS     = mcg_pkg::MAX_SLOTS_DEF,
   parameter int  CHARSET_DEPTH = mcg_pkg::CHARSET_DEPTH_DEF,
   localparam int POS_W         = $clog2(CHARSET_DEPTH)
) (
   input  logic                          clock,
   input  logic                          reset,
   input  mcg_pkg::odo_ctl_type          ctl,
   input  logic [mcg_pkg::SLOT_W-1:0]    slot,
   input  logic [mcg_pkg::POSF_W-1:0]    position,
   input  logic [mcg_pkg::SIZEF_W-1:0]   charset_size,
   input  logic [MAX_SLOTS-1:0]          lane_en,
   output logic [MAX_SLOTS*POS_W-1:0]    pos_flat,
   output logic                          wrap
);
   import mcg_pkg::*;

   localparam int SZ_W = $clog2(CHARSET_DEPTH + 1);

   logic [POS_W-1:0]     pos_ff  [MAX_SLOTS];
   logic [POS_W-1:0]     pos_in  [MAX_SLOTS];
   logic [SZ_W-1:0]      size_ff [MAX_SLOTS];
   logic [SZ_W-1:0]      size_in [MAX_SLOTS];
   logic [SZ_W-1:0]      inc     [MAX_SLOTS];
   logic [MAX_SLOTS-1:0] digit_wrap;
   logic [MAX_SLOTS-1:0] carry;
   logic [MAX_SLOTS-1:0] lsd;
   logic                 chain;
   logic [SZ_W-1:0]      new_size;
   logic [SZ_W-1:0]      sel_size;
   logic                 pos_fits;

   // lowest-order digit is the last enabled slot
   always_comb begin
      for (int i = 0; i < MAX_SLOTS; i++) begin
         if (i == MAX_SLOTS - 1) begin
            lsd[i] = lane_en[i];
         end else begin
            lsd[i] = lane_en[i] & ~lane_en[i+1];
         end
      end
   end

   // per-digit increment and ripple carry toward slot 0
   always_comb begin
      chain = 1'b0;
      for (int i = MAX_SLOTS - 1; i >= 0; i--) begin
         inc[i]        = SZ_W'(pos_ff[i]) + SZ_W'(1);
         digit_wrap[i] = (inc[i] >= size_ff[i]);
         carry[i]      = lsd[i] | chain;
         chain         = carry[i] & digit_wrap[i] & lane_en[i];
      end
      wrap = carry[0] & digit_wrap[0];
   end

   // size clamp and restored position check
   always_comb begin
      if (charset_size == '0) begin
         new_size = SZ_W'(1);
      end else if (charset_size > SIZEF_W'(CHARSET_DEPTH)) begin
         new_size = SZ_W'(CHARSET_DEPTH);
      end else begin
         new_size = charset_size[SZ_W-1:0];
      end
      sel_size = size_ff[0];
      for (int i = 0; i < MAX_SLOTS; i++) begin
         if (slot == SLOT_W'(i)) begin
            sel_size = size_ff[i];
         end
      end
      pos_fits = ({1'b0, position} < SIZEF_W'(sel_size));
   end

   // next positions and sizes
   always_comb begin
      for (int i = 0; i < MAX_SLOTS; i++) begin
         pos_in[i]  = pos_ff[i];
         size_in[i] = size_ff[i];
         if (ctl.clear) begin
            pos_in[i] = '0;
         end else if (ctl.step && carry[i]) begin
            pos_in[i] = digit_wrap[i] ? '0 : inc[i][POS_W-1:0];
         end else if (ctl.set_size && (slot == SLOT_W'(i))) begin
            size_in[i] = new_size;
            if (SZ_W'(pos_ff[i]) >= new_size) begin
               pos_in[i] = '0;
            end
         end else if (ctl.set_pos && (slot == SLOT_W'(i))) begin
            pos_in[i] = pos_fits ? position[POS_W-1:0] : '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < MAX_SLOTS; i++) begin
            pos_ff[i]  <= '0;
            size_ff[i] <= SZ_W'(1);
         end
      end else begin
         for (int i = 0; i < MAX_SLOTS; i++) begin
            pos_ff[i]  <= pos_in[i];
            size_ff[i] <= size_in[i];
         end
      end
   end

   // read addresses for the charset banks
   always_comb begin
      for (int i = 0; i < MAX_SLOTS; i++) begin
         pos_flat[i*POS_W +: POS_W] = pos_ff[i];
      end
   end

endmodule

[rtl/mcg_seq.sv]
`include "mask_candidate_generator_defines.svh"

module mcg_seq #(
   parameter int  MAX_BATCH = mcg_pkg::MAX_BATCH_DEF,
   localparam int BAT_W     = $clog2(MAX_BATCH + 1)
) (
   input  logic                           clock,
   input  logic                           reset,
   input  mcg_pkg::seq_cmd_type           cmd,
   input  logic [mcg_pkg::BATCHF_W-1:0]   batch_size,
   input  logic [mcg_pkg::COUNT_W-1:0]    count_value,
   input  logic                           wrap,
   output logic                           step,
   output logic                           busy,
   output logic                           rsp_valid,
   output mcg_pkg::rsp_meta_type          meta
);
   import mcg_pkg::*;

   st_type               st_ff, st_in;
   logic [BAT_W-1:0]     issued_ff, issued_in;
   logic [BAT_W-1:0]     limit_ff, limit_in;
   logic [COUNT_W-1:0]   count_ff, count_in;
   logic                 done_ff, done_in;
   logic                 vld_ff, vld_in;
   rsp_meta_type         meta_ff, meta_in;
   logic                 last;

   // batch control: one candidate issued per run cycle
   always_comb begin
      st_in     = st_ff;
      issued_in = issued_ff;
      limit_in  = limit_ff;
      count_in  = count_ff;
      done_in   = done_ff;
      vld_in    = 1'b0;
      meta_in   = meta_ff;
      step      = 1'b0;
      last      = 1'b0;
      unique case (st_ff)
         ST_IDLE: begin
            if (cmd.gen && !done_ff && (batch_size != '0)) begin
               st_in     = ST_RUN;
               issued_in = '0;
               limit_in  = (batch_size > BATCHF_W'(MAX_BATCH)) ?
                           BAT_W'(MAX_BATCH) : batch_size[BAT_W-1:0];
            end
            if (cmd.set_count) begin
               count_in = count_value;
               done_in  = 1'b0;
            end
            if (cmd.restart) begin
               count_in = '0;
               done_in  = 1'b0;
            end
            if (cmd.clr_done) begin
               done_in = 1'b0;
            end
         end
         ST_RUN: begin
            step      = 1'b1;
            issued_in = issued_ff + BAT_W'(1);
            last      = wrap | (issued_in == limit_ff);
            count_in  = count_ff + COUNT_W'(1);
            done_in   = wrap;
            vld_in    = 1'b1;
            meta_in.last_of_batch   = last;
            meta_in.exhausted       = wrap;
            meta_in.generated_total = count_in;
            if (last) begin
               st_in = ST_IDLE;
            end
         end
         default: begin
            st_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff     <= ST_IDLE;
         issued_ff <= '0;
         limit_ff  <= '0;
         count_ff  <= '0;
         done_ff   <= 1'b0;
         vld_ff    <= 1'b0;
      end else begin
         st_ff     <= st_in;
         issued_ff <= issued_in;
         limit_ff  <= limit_in;
         count_ff  <= count_in;
         done_ff   <= done_in;
         vld_ff    <= vld_in;
      end
   end

   // flags travel alongside the charset read latency
   always_ff @(posedge clock) begin
      meta_ff <= meta_in;
   end

   assign busy      = (st_ff == ST_RUN) | vld_ff;
   assign rsp_valid = vld_ff;
   assign meta      = meta_ff;

   `MCG_ASSERT_IMPL(a_run_not_done, clock, reset, st_ff == ST_RUN, !done_ff, "run while exhausted")
   `MCG_ASSERT_NEXT(a_run_strobes, clock, reset, st_ff == ST_RUN, vld_ff, "run cycle gave no item")
   `MCG_ASSERT_IMPL(a_exh_is_last, clock, reset, vld_ff && meta_ff.exhausted, meta_ff.last_of_batch, "exhausted item not last")
   `MCG_ASSERT_IMPL(a_issued_below_limit, clock, reset, st_ff == ST_RUN, issued_ff < limit_ff, "batch overrun")
   `MCG_ASSERT_NEXT(a_wrap_ends_batch, clock, reset, (st_ff == ST_RUN) && wrap, done_ff && (st_ff == ST_IDLE), "wrap did not end batch")

endmodule

[rtl/mask_candidate_generator.sv]
// channel    direction  ports                                   handshake
// request    in         start, busy, req_item                   taken when start && !busy
// response   out        rsp_strobe, rsp_item                    one strobe per item, no stall
// config     in         csr_write_en, csr_write_data            written when csr_write_en
//
// non-generate commands do not raise busy; busy stays low after them.
// a generate item keeps busy high after the accept while it issues its candidates:
// one candidate per cycle, reading all slot banks at once, and on through the
// registered bank read until the last item shows on rsp_strobe.
// reset is synchronous; it clears positions, sizes to one, count and flags.
// the receiver cannot stall, so items stream out one per cycle.
module mask_candidate_generator #(
   parameter int MAX_SLOTS     = mcg_pkg::MAX_SLOTS_DEF,
   parameter int CHARSET_DEPTH = mcg_pkg::CHARSET_DEPTH_DEF,
   parameter int MAX_BATCH     = mcg_pkg::MAX_BATCH_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   output logic                       busy,
   input  mcg_pkg::req_type           req_item,
   output logic                       rsp_strobe,
   output mcg_pkg::rsp_type           rsp_item,
   input  logic                       csr_write_en,
   input  logic [mcg_pkg::CSR_W-1:0]  csr_write_data
);
   import mcg_pkg::*;

   localparam int POS_W = $clog2(CHARSET_DEPTH);

   logic [CSR_W-1:0]             csr_slots_ff;
   logic [MAX_SLOTS-1:0]         lane_en;
   logic                         accept;
   logic                         slot_ok;
   logic                         load_en;
   odo_ctl_type                  odo_ctl;
   seq_cmd_type                  seq_cmd;
   logic                         step;
   logic                         wrap;
   logic [MAX_SLOTS*POS_W-1:0]   pos_flat;
   logic [MAX_SLOTS*CHAR_W-1:0]  rd_data_flat;
   rsp_meta_type                 meta;
   logic [CAND_W-1:0]            candidate;

   // slot count register
   always_ff @(posedge clock) begin
      if (reset) begin
         csr_slots_ff <= SLOT_COUNT_RST;
      end else if (csr_write_en) begin
         csr_slots_ff <= csr_write_data;
      end
   end

   // active slots: zero acts as one, large values cover all slots
   always_comb begin
      for (int i = 0; i < MAX_SLOTS; i++) begin
         lane_en[i] = (i == 0) || (int'(csr_slots_ff) > i);
      end
   end

   // command decode
   assign accept  = start & ~busy;
   assign slot_ok = (int'(req_item.slot) < MAX_SLOTS);
   assign load_en = accept && (req_item.command == CMD_LOAD) && slot_ok &&
                    (int'(req_item.position) < CHARSET_DEPTH);

   always_comb begin
      odo_ctl.clear     = accept && (req_item.command == CMD_RESTART);
      odo_ctl.step      = step;
      odo_ctl.set_size  = accept && (req_item.command == CMD_SIZE) && slot_ok;
      odo_ctl.set_pos   = accept && (req_item.command == CMD_POS) && slot_ok;
      seq_cmd.gen       = accept && (req_item.command == CMD_GEN);
      seq_cmd.set_count = accept && (req_item.command == CMD_COUNT);
      seq_cmd.restart   = odo_ctl.clear;
      seq_cmd.clr_done  = odo_ctl.set_pos;
   end

   mcg_charset_mem #(
      .MAX_SLOTS     (MAX_SLOTS),
      .CHARSET_DEPTH (CHARSET_DEPTH)
   ) u_mem (
      .clock        (clock),
      .wr_en        (load_en),
      .wr_slot      (req_item.slot),
      .wr_addr      (req_item.position[POS_W-1:0]),
      .wr_data      (req_item.char_code),
      .rd_en        (step),
      .rd_addr_flat (pos_flat),
      .rd_data_flat (rd_data_flat)
   );

   mcg_odometer #(
      .MAX_SLOTS     (MAX_SLOTS),
      .CHARSET_DEPTH (CHARSET_DEPTH)
   ) u_odo (
      .clock        (clock),
      .reset        (reset),
      .ctl          (odo_ctl),
      .slot         (req_item.slot),
      .position     (req_item.position),
      .charset_size (req_item.charset_size),
      .lane_en      (lane_en),
      .pos_flat     (pos_flat),
      .wrap         (wrap)
   );

   mcg_seq #(
      .MAX_BATCH (MAX_BATCH)
   ) u_seq (
      .clock       (clock),
      .reset       (reset),
      .cmd         (seq_cmd),
      .batch_size  (req_item.batch_size),
      .count_value (req_item.count_value),
      .wrap        (wrap),
      .step        (step),
      .busy        (busy),
      .rsp_valid   (rsp_strobe),
      .meta        (meta)
   );

   // pack candidate, unused slots read as zero
   always_comb begin
      candidate = '0;
      for (int i = 0; i < MAX_SLOTS; i++) begin
         if (lane_en[i]) begin
            candidate[i*CHAR_W +: CHAR_W] = rd_data_flat[i*CHAR_W +: CHAR_W];
         end
      end
   end

   always_comb begin
      rsp_item.candidate       = candidate;
      rsp_item.last_of_batch   = meta.last_of_batch;
      rsp_item.exhausted       = meta.exhausted;
      rsp_item.generated_total = meta.generated_total;
   end

endmodule

[bench/candidate_checker.sv]
module candidate_checker (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic                       busy,
   input  mcg_pkg::req_type           req_item,
   input  logic                       rsp_strobe,
   input  mcg_pkg::rsp_type           rsp_item,
   input  logic                       csr_write_en,
   input  logic [mcg_pkg::CSR_W-1:0]  csr_write_data,
   output int                         mismatches,
   output int                         outstanding,
   output int                         checked,
   output int                         wraps
);
   import mcg_pkg::*;

   localparam int SLOTS = MAX_SLOTS_DEF;
   localparam int DEPTH = CHARSET_DEPTH_DEF;
   localparam int BATCH = MAX_BATCH_DEF;

   // shadow of the enumerator state
   logic [CHAR_W-1:0]  char_table [SLOTS][DEPTH];
   logic [SIZEF_W-1:0] table_size [SLOTS];
   logic [SIZEF_W-1:0] digit [SLOTS];
   logic [COUNT_W-1:0] total;
   bit                 spent;
   logic [CSR_W-1:0]   slot_count;

   // candidates predicted but not yet seen, oldest first
   rsp_type due_candidates [$];

   task automatic clear_digits();
      for (int i = 0; i < SLOTS; i++) digit[i] = '0;
   endtask

   // walk the odometer for one batch, last active slot least significant
   task automatic enumerate_batch(input logic [BATCHF_W-1:0] batch);
      int      width;
      int      limit;
      int      emitted;
      int      i;
      bit      rolled;
      rsp_type cand;
      width = (slot_count == 0) ? 1 : ((slot_count > SLOTS) ? SLOTS : int'(slot_count));
      limit = (batch > BATCH) ? BATCH : int'(batch);
      emitted = 0;
      while (emitted < limit && !spent) begin
         cand = '0;
         for (i = 0; i < width; i++) cand.candidate[8*i +: 8] = char_table[i][digit[i]];
         rolled = 1'b1;
         i = width;
         while (rolled && i > 0) begin
            i--;
            digit[i] = digit[i] + 1'b1;
            if (digit[i] < table_size[i]) rolled = 1'b0;
            else digit[i] = '0;
         end
         spent = rolled;
         total = total + 1'b1;
         emitted++;
         cand.last_of_batch = spent || (emitted == limit);
         cand.exhausted = spent;
         cand.generated_total = total;
         due_candidates.insert(due_candidates.size(), cand);
         if (spent) wraps++;
      end
   endtask

   // state update for one accepted item
   task automatic apply_item(input req_type item);
      logic [SIZEF_W-1:0] kept;
      case (item.command)
         CMD_LOAD: begin
            char_table[item.slot][item.position] = item.char_code;
         end
         CMD_SIZE: begin
            kept = item.charset_size;
            if (kept == 0) kept = SIZEF_W'(1);
            if (kept > DEPTH) kept = SIZEF_W'(DEPTH);
            table_size[item.slot] = kept;
            if (digit[item.slot] >= kept) digit[item.slot] = '0;
         end
         CMD_GEN: begin
            enumerate_batch(item.batch_size);
         end
         CMD_POS: begin
            digit[item.slot] = (item.position < table_size[item.slot]) ?
                               SIZEF_W'(item.position) : '0;
            spent = 1'b0;
         end
         CMD_COUNT: begin
            total = item.count_value;
            spent = 1'b0;
         end
         CMD_RESTART: begin
            clear_digits();
            total = '0;
            spent = 1'b0;
         end
         default: begin
         end
      endcase
   endtask

   // compare one strobed candidate with the oldest prediction
   task automatic check_candidate(input rsp_type seen);
      rsp_type want;
      if (due_candidates.size() == 0) begin
         $error("unexpected candidate %h total %h", seen.candidate, seen.generated_total);
         mismatches++;
      end else begin
         want = due_candidates.pop_front();
         checked++;
         if (seen.candidate !== want.candidate) begin
            $error("candidate: expected %h, got %h", want.candidate, seen.candidate);
            mismatches++;
         end
         if (seen.last_of_batch !== want.last_of_batch) begin
            $error("last_of_batch: expected %b, got %b", want.last_of_batch,
                   seen.last_of_batch);
            mismatches++;
         end
         if (seen.exhausted !== want.exhausted) begin
            $error("exhausted: expected %b, got %b", want.exhausted, seen.exhausted);
            mismatches++;
         end
         if (seen.generated_total !== want.generated_total) begin
            $error("generated_total: expected %h, got %h", want.generated_total,
                   seen.generated_total);
            mismatches++;
         end
      end
   endtask

   // everything is sampled on the rising edge
   always @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < SLOTS; i++) table_size[i] = SIZEF_W'(1);
         clear_digits();
         total = '0;
         spent = 1'b0;
         slot_count = SLOT_COUNT_RST;
         due_candidates.delete();
      end else begin
         if (rsp_strobe) check_candidate(rsp_item);
         if (start && !busy) apply_item(req_item);
         if (csr_write_en) slot_count = csr_write_data;
      end
      outstanding = due_candidates.size();
   end

endmodule

[bench/testbench.sv]
module testbench;
   import mcg_pkg::*;

   localparam int WIDE_SLOT    = 5;
   localparam int RANDOM_ITEMS = 250;
   localparam int QUIET_TAIL   = 40;
   localparam int PHASES       = 6;
   localparam int SETTLE       = 4;
   localparam int FULL_DEPTH   = CHARSET_DEPTH_DEF;
   // command codes the block leaves unused
   localparam logic [CMD_W-1:0] CMD_SPARE_LO = 3'd6;
   localparam logic [CMD_W-1:0] CMD_SPARE_HI = 3'd7;

   logic                clock = 1'b0;
   logic                reset;
   logic                start;
   logic                busy;
   logic                rsp_strobe;
   logic                csr_write_en;
   logic [CSR_W-1:0]    csr_write_data;
   req_type             req_item;
   rsp_type             rsp_item;
   int                  mismatches;
   int                  outstanding;
   int                  checked;
   int                  wraps;

   // stimulus bookkeeping: which table entries hold data, current sizes
   bit                  loaded [MAX_SLOTS_DEF][CHARSET_DEPTH_DEF];
   int                  size_of [MAX_SLOTS_DEF];
   bit                  idling_on;
   int                  items_sent;
   int                  batches_sent;
   logic [CSR_W-1:0]    slot_count_plan [PHASES] = '{4'd15, 4'd1, 4'd0, 4'd8, 4'd3, 4'd7};

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   mask_candidate_generator dut (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_item       (req_item),
      .rsp_strobe     (rsp_strobe),
      .rsp_item       (rsp_item),
      .csr_write_en   (csr_write_en),
      .csr_write_data (csr_write_data)
   );

   candidate_checker result_watch (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_item       (req_item),
      .rsp_strobe     (rsp_strobe),
      .rsp_item       (rsp_item),
      .csr_write_en   (csr_write_en),
      .csr_write_data (csr_write_data),
      .mismatches     (mismatches),
      .outstanding    (outstanding),
      .checked        (checked),
      .wraps          (wraps)
   );

   // drive one item at a falling edge, hold until taken
   task automatic issue(input req_type item);
      int gap;
      gap = 0;
      if (idling_on && $urandom_range(0, 3) == 0) gap = $urandom_range(1, 8);
      @(negedge clock);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      start <= 1'b1;
      req_item <= item;
      @(posedge clock);
      while (busy) @(posedge clock);
      items_sent++;
      if (item.command == CMD_GEN) batches_sent++;
   endtask

   // random filler for the fields a command ignores
   function automatic req_type noise();
      req_type item;
      item.command = cmd_type'($urandom_range(0, 7));
      item.slot = SLOT_W'($urandom);
      item.position = POSF_W'($urandom);
      item.char_code = CHAR_W'($urandom);
      item.charset_size = SIZEF_W'($urandom);
      item.batch_size = BATCHF_W'($urandom);
      item.count_value = {$urandom, $urandom};
      return item;
   endfunction

   task automatic plain(input logic [CMD_W-1:0] code);
      req_type item;
      item = noise();
      item.command = cmd_type'(code);
      issue(item);
   endtask

   task automatic load_entry(input int slot, input int pos, input logic [CHAR_W-1:0] code);
      req_type item;
      item = noise();
      item.command = CMD_LOAD;
      item.slot = SLOT_W'(slot);
      item.position = POSF_W'(pos);
      item.char_code = code;
      issue(item);
      loaded[slot][pos] = 1'b1;
   endtask

   // size command alone, no table fill
   task automatic resize(input int slot, input int size);
      req_type item;
      item = noise();
      item.command = CMD_SIZE;
      item.slot = SLOT_W'(slot);
      item.charset_size = SIZEF_W'(size);
      issue(item);
      size_of[slot] = (size == 0) ? 1 : ((size > FULL_DEPTH) ? FULL_DEPTH : size);
   endtask

   // fill every entry the new size makes reachable before resizing
   task automatic set_size(input int slot, input int size);
      int      kept;
      int      p;
      kept = (size == 0) ? 1 : ((size > FULL_DEPTH) ? FULL_DEPTH : size);
      for (p = 0; p < kept; p++)
         if (!loaded[slot][p]) load_entry(slot, p, CHAR_W'($urandom));
      resize(slot, size);
   endtask

   task automatic set_position(input int slot, input int pos);
      req_type item;
      item = noise();
      item.command = CMD_POS;
      item.slot = SLOT_W'(slot);
      item.position = POSF_W'(pos);
      issue(item);
   endtask

   task automatic set_count(input logic [COUNT_W-1:0] value);
      req_type item;
      item = noise();
      item.command = CMD_COUNT;
      item.count_value = value;
      issue(item);
   endtask

   task automatic request_batch(input int batch);
      req_type item;
      item = noise();
      item.command = CMD_GEN;
      item.batch_size = BATCHF_W'(batch);
      issue(item);
   endtask

   // hold off until every predicted candidate is out and the block is idle
   task automatic drain();
      @(negedge clock);
      start <= 1'b0;
      while (outstanding != 0 || busy) @(negedge clock);
      repeat (SETTLE) @(negedge clock);
   endtask

   task automatic write_slot_count(input logic [CSR_W-1:0] value);
      drain();
      csr_write_data <= value;
      csr_write_en <= 1'b1;
      @(negedge clock);
      csr_write_en <= 1'b0;
   endtask

   initial begin
      int pick;
      int slot;
      int phase;
      int base;
      int amount;
      int lowest;
      reset = 1'b1;
      start = 1'b0;
      req_item = '0;
      csr_write_en = 1'b0;
      csr_write_data = '0;
      idling_on = 1'b1;
      for (int s = 0; s < MAX_SLOTS_DEF; s++) size_of[s] = 1;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: first entry of every table, alternating extreme bytes
      for (int s = 0; s < MAX_SLOTS_DEF; s++) load_entry(s, 0, (s % 2) ? 8'h00 : 8'hFF);
      // count wraps past all ones; single-point space is spent at once
      set_count('1);
      request_batch(2);
      // generate while spent gives nothing
      request_batch(5);
      plain(CMD_RESTART);
      // size above the table depth clamps to full depth; the walk reads only the top entries
      load_entry(WIDE_SLOT, FULL_DEPTH - 2, 8'h5A);
      load_entry(WIDE_SLOT, FULL_DEPTH - 1, 8'hA5);
      resize(WIDE_SLOT, 511);
      set_position(WIDE_SLOT, FULL_DEPTH - 2);
      request_batch(3);
      plain(CMD_RESTART);
      // shrinking a size below the position resets it
      set_position(WIDE_SLOT, FULL_DEPTH - 2);
      set_size(WIDE_SLOT, 24);
      // clamped zero size, small table on one slot
      set_size(4, 0);
      set_size(3, 3);
      // oversized batch walks the wide slot
      request_batch(127);
      set_position(WIDE_SLOT, 20);
      request_batch(10);
      // wrap all the way round
      set_position(3, 2);
      set_position(WIDE_SLOT, 22);
      request_batch(10);
      // restored position past the size falls back to zero
      set_position(2, 9);
      set_count({$urandom, $urandom});
      plain(CMD_SPARE_LO);
      plain(CMD_SPARE_HI);
      request_batch(0);
      request_batch(1);

      // random part in phases, one slot count per phase
      base = items_sent;
      phase = 0;
      while (items_sent - base < RANDOM_ITEMS) begin
         if (phase < PHASES && items_sent - base >= phase * (RANDOM_ITEMS / PHASES)) begin
            write_slot_count(slot_count_plan[phase]);
            phase++;
         end
         idling_on = (items_sent - base < RANDOM_ITEMS - QUIET_TAIL);
         slot = $urandom_range(0, MAX_SLOTS_DEF - 1);
         pick = $urandom_range(0, 99);
         if (pick < 35 || pick >= 97) begin
            amount = $urandom_range(0, 99);
            if (amount < 5) request_batch(0);
            else if (amount < 12) request_batch($urandom_range(65, 127));
            else if (amount < 20) request_batch(64);
            else request_batch($urandom_range(1, 20));
         end else if (pick < 50) begin
            amount = $urandom_range(0, 99);
            if (amount < 5) set_size(slot, 0);
            else if (slot == WIDE_SLOT && amount < 15) set_size(slot, $urandom_range(25, 48));
            else if (amount < 75) set_size(slot, $urandom_range(1, 6));
            else set_size(slot, $urandom_range(7, 24));
         end else if (pick < 65) begin
            amount = $urandom_range(0, 99);
            if (amount < 40) set_position(slot, $urandom_range(0, size_of[slot] - 1));
            else if (amount < 65) set_position(slot, size_of[slot] - 1);
            else set_position(slot, $urandom_range(0, 255));
         end else if (pick < 73) begin
            // park the low-order digits at their top so the space runs out soon
            lowest = $urandom_range(0, MAX_SLOTS_DEF - 1);
            for (int s = lowest; s < MAX_SLOTS_DEF; s++) set_position(s, size_of[s] - 1);
            request_batch($urandom_range(1, 64));
         end else if (pick < 80) begin
            load_entry(slot, $urandom_range(0, 255), CHAR_W'($urandom));
         end else if (pick < 86) begin
            if ($urandom_range(0, 1)) set_count('1 - $urandom_range(0, 40));
            else set_count({$urandom, $urandom});
         end else if (pick < 91) begin
            plain(CMD_RESTART);
         end else if (pick < 95) begin
            plain($urandom_range(0, 1) ? CMD_SPARE_LO : CMD_SPARE_HI);
         end else begin
            drain();
         end
      end

      drain();
      $display("covered %0d items, %0d batch requests, %0d candidates checked, %0d wraps",
               items_sent, batches_sent, checked, wraps);
      $display("slot counts swept across 0 to 15, table sizes from 1 to the full depth");
      if (mismatches == 0 && outstanding == 0) begin
         $display("testbench: clean");
      end else begin
         $display("testbench: errors");
      end
      $finish;
   end

   // safety net well beyond the slowest legal run
   initial begin
      #2400000;
      $display("testbench: errors");
      $finish;
   end

endmodule
